>>> hw/rtl/m32k_pkg.sv
// shared types and constants for the matern 3/2 kernel and gradient block
package m32k_pkg;

  localparam int FRAC_BITS = 16;

  // configuration register indexes
  localparam logic [2:0] REG_DIMENSIONS              = 3'd0;
  localparam logic [2:0] REG_SQRT3_OVER_LENGTH       = 3'd1;
  localparam logic [2:0] REG_THREE_OVER_LENGTH_CUBED = 3'd2;
  localparam logic [2:0] REG_WANT_KERNEL             = 3'd3;
  localparam logic [2:0] REG_WANT_GRADIENT           = 3'd4;

  // ln2 in q.32 and floor(2^48 / ln2_q32) for the range reduction estimate
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [16:0] LN2_RECIP = 17'((64'd1 << 48) / 64'd2977044472);
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

  // number of horner terms in the exp series
  localparam int HORNER_TERMS = 12;
  // isqrt steps: two radicand bits per step over d2 << FRAC_BITS
  localparam int SQRT_STEPS   = (32 + FRAC_BITS) / 2;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic               last_pair;
  } in_t;

  typedef struct packed {
    logic [31:0] kernel_value;
    logic [31:0] gradient_value;
    logic        saturated;
    logic        last_result;
  } out_t;

  typedef struct packed {
    in_t  pts;
    logic use_y;
    logic use_z;
    logic want_k;
    logic want_g;
  } job_t;

  typedef struct packed {
    logic [31:0] s3l;
    logic [31:0] t3l;
  } scale_t;

  // sideband carried down the back pipeline
  typedef struct packed {
    logic        last;
    logic        want_k;
    logic        want_g;
    logic        sat;
    logic [47:0] g1;
    logic [20:0] um;
    logic        big;
    logic [5:0]  k;
  } side_t;

endpackage

>>> hw/rtl/m32k_front.sv
// front end: configuration registers, command accept and item classification
module m32k_front import m32k_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        q_full,
  output logic        push,
  output job_t        job,
  output scale_t      scale
);

  logic [1:0]  dimensions;
  logic [31:0] sqrt3_over_length;
  logic [31:0] three_over_length_cubed;
  logic        want_kernel;
  logic        want_gradient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions              <= 2'd3;
      sqrt3_over_length       <= 32'd113512;
      three_over_length_cubed <= 32'd196608;
      want_kernel             <= 1'b1;
      want_gradient           <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIMENSIONS:              dimensions <= cfg_data[1:0];
        REG_SQRT3_OVER_LENGTH:       sqrt3_over_length <= cfg_data;
        REG_THREE_OVER_LENGTH_CUBED: three_over_length_cubed <= cfg_data;
        REG_WANT_KERNEL:             want_kernel <= cfg_data[0];
        REG_WANT_GRADIENT:           want_gradient <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;
  assign push = start & ~q_full;

  // zero dimensions acts as one, so only the high bit decides y
  always_comb begin
    job.pts    = item;
    job.use_y  = dimensions[1];
    job.use_z  = (dimensions == 2'd3);
    job.want_k = want_kernel;
    job.want_g = want_gradient;
  end

  assign scale.s3l = sqrt3_over_length;
  assign scale.t3l = three_over_length_cubed;

endmodule

>>> hw/rtl/m32k_queue.sv
// two-entry queue between front and back, drained every cycle it holds data
module m32k_queue import m32k_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  output logic valid,
  output job_t rdata
);

  job_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/m32k_back.sv
// back end: distance, isqrt, range reduction, exp series and output products
module m32k_back import m32k_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  job_t   job,
  input  scale_t scale,
  output logic   done,
  output out_t   result
);

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // ---- differences
  logic        v1;
  logic [31:0] dx, dy, dz;
  side_t       s1;
  side_t       s1_next;

  always_comb begin
    s1_next        = '0;
    s1_next.last   = job.pts.last_pair;
    s1_next.want_k = job.want_k;
    s1_next.want_g = job.want_g;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    dx <= abs_diff(job.pts.a_x, job.pts.b_x);
    dy <= job.use_y ? abs_diff(job.pts.a_y, job.pts.b_y) : 32'd0;
    dz <= job.use_z ? abs_diff(job.pts.a_z, job.pts.b_z) : 32'd0;
    s1 <= s1_next;
  end

  // ---- squares
  logic        v2;
  logic [63:0] sqx, sqy, sqz;
  side_t       s2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    sqx <= 64'(dx) * 64'(dx);
    sqy <= 64'(dy) * 64'(dy);
    sqz <= 64'(dz) * 64'(dz);
    s2  <= s1;
  end

  // ---- sum and clip into d2, seeds the isqrt
  logic [65:0] dsum;
  logic        dsat;
  logic [31:0] d2;

  assign dsum = 66'(sqx) + 66'(sqy) + 66'(sqz);
  assign dsat = |dsum[65:48];
  assign d2   = dsat ? 32'hFFFF_FFFF : dsum[47:16];

  logic        sq_v    [SQRT_STEPS+1];
  logic [47:0] sq_rad  [SQRT_STEPS+1];
  logic [25:0] sq_rem  [SQRT_STEPS+1];
  logic [23:0] sq_root [SQRT_STEPS+1];
  side_t       sq_s    [SQRT_STEPS+1];
  side_t       sq_s0_next;

  always_comb begin
    sq_s0_next     = s2;
    sq_s0_next.sat = dsat;
  end

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v2;
  end

  always_ff @(posedge clk) begin
    sq_rad[0]  <= {d2, 16'd0};
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_s[0]    <= sq_s0_next;
  end

  // ---- isqrt, one root bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [27:0] remx;
    logic [28:0] trial;

    assign remx  = {sq_rem[j], sq_rad[j][47-2*j -: 2]};
    assign trial = {1'b0, remx} - {3'b000, sq_root[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else     sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      sq_rad[j+1] <= sq_rad[j];
      if (!trial[28]) begin
        sq_rem[j+1]  <= trial[25:0];
        sq_root[j+1] <= {sq_root[j][22:0], 1'b1};
      end else begin
        sq_rem[j+1]  <= remx[25:0];
        sq_root[j+1] <= {sq_root[j][22:0], 1'b0};
      end
    end

    if (j == 0) begin : g_grad_scale
      logic [63:0] gprod;
      side_t       s_next;
      assign gprod = 64'(scale.t3l) * 64'(sq_rad[0][47:16]);
      always_comb begin
        s_next    = sq_s[0];
        s_next.g1 = gprod[63:16];
      end
      always_ff @(posedge clk) begin
        sq_s[1] <= s_next;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        sq_s[j+1] <= sq_s[j];
      end
    end
  end

  // ---- u = sqrt3/l * d
  logic        vu;
  logic [39:0] uval;
  side_t       su;
  logic [55:0] uprod;

  assign uprod = 56'(scale.s3l) * 56'(sq_root[SQRT_STEPS]);

  always_ff @(posedge clk) begin
    if (rst) vu <= 1'b0;
    else     vu <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    uval <= uprod[55:16];
    su   <= sq_s[SQRT_STEPS];
  end

  // ---- quotient estimate by ln2, may be one low
  logic        vk;
  side_t       sk;
  side_t       sk_next;
  logic [37:0] kprod;

  assign kprod = 38'(uval[20:0]) * 38'(LN2_RECIP);

  always_comb begin
    sk_next     = su;
    sk_next.um  = uval[20:0];
    sk_next.big = |uval[39:21];
    sk_next.k   = kprod[37:32];
  end

  always_ff @(posedge clk) begin
    if (rst) vk <= 1'b0;
    else     vk <= vu;
  end

  always_ff @(posedge clk) begin
    sk <= sk_next;
  end

  // ---- remainder with one correction step
  logic        hv [HORNER_TERMS+1];
  logic [31:0] hr [HORNER_TERMS+1];
  logic [32:0] hp [HORNER_TERMS+1];
  side_t       hs [HORNER_TERMS+1];
  logic [37:0] xval, kl, r0;
  logic        rfix;
  side_t       hs0_next;

  assign xval = {1'b0, sk.um, 16'd0};
  assign kl   = 38'(sk.k) * 38'(LN2_Q32);
  assign r0   = xval - kl;
  assign rfix = (r0 >= 38'(LN2_Q32));

  always_comb begin
    hs0_next = sk;
    if (rfix) begin
      hs0_next.k = sk.k + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) hv[0] <= 1'b0;
    else     hv[0] <= vk;
  end

  always_ff @(posedge clk) begin
    hs[0] <= hs0_next;
    hp[0] <= ONE_Q32;
    if (rfix) begin
      hr[0] <= 32'(r0 - 38'(LN2_Q32));
    end else begin
      hr[0] <= r0[31:0];
    end
  end

  // ---- horner steps: product, reciprocal multiply, correct and subtract
  for (genvar s = 0; s < HORNER_TERMS; s++) begin : g_horner
    localparam int          N  = HORNER_TERMS - s;
    localparam logic [34:0] MN = 35'((64'd1 << 34) / N);

    logic        av, bv;
    logic [31:0] aq, ar, bq, br, best;
    side_t       as_s, bs_s;
    logic [63:0] pa;
    logic [66:0] pb;
    logic [35:0] en, rm;
    logic [31:0] quot;

    assign pa   = 64'(hr[s]) * 64'(hp[s]);
    assign pb   = 67'(aq) * 67'(MN);
    assign en   = 36'(best) * 36'(N);
    assign rm   = 36'(bq) - en;
    assign quot = best + 32'(rm >= 36'(N));

    always_ff @(posedge clk) begin
      if (rst) begin
        av        <= 1'b0;
        bv        <= 1'b0;
        hv[s+1]   <= 1'b0;
      end else begin
        av        <= hv[s];
        bv        <= av;
        hv[s+1]   <= bv;
      end
    end

    always_ff @(posedge clk) begin
      aq      <= pa[63:32];
      ar      <= hr[s];
      as_s    <= hs[s];
      best    <= pb[65:34];
      bq      <= aq;
      br      <= ar;
      bs_s    <= as_s;
      hp[s+1] <= ONE_Q32 - 33'(quot);
      hr[s+1] <= br;
      hs[s+1] <= bs_s;
    end
  end

  // ---- t = p >> (k + 1)
  logic        vt;
  logic [31:0] tval;
  side_t       st;
  logic [6:0]  tsh;
  logic [32:0] tsr;

  assign tsh = 7'(hs[HORNER_TERMS].k) + 7'd1;
  assign tsr = hp[HORNER_TERMS] >> tsh;

  always_ff @(posedge clk) begin
    if (rst) vt <= 1'b0;
    else     vt <= hv[HORNER_TERMS];
  end

  always_ff @(posedge clk) begin
    tval <= hs[HORNER_TERMS].big ? 32'd0 : tsr[31:0];
    st   <= hs[HORNER_TERMS];
  end

  // ---- output products
  logic        vm;
  logic [53:0] pk;
  logic [47:0] ph;
  logic [63:0] pl;
  side_t       sm;
  logic [21:0] kf;

  assign kf = 22'(st.um) + 22'(1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else     vm <= vt;
  end

  always_ff @(posedge clk) begin
    pk <= 54'(kf) * 54'(tval);
    ph <= 48'(st.g1[47:32]) * 48'(tval);
    pl <= 64'(st.g1[31:0]) * 64'(tval);
    sm <= st;
  end

  // ---- clamp, gate and register the result
  logic [37:0] kern_w;
  logic [31:0] kern;
  logic [49:0] gsum;
  logic        gsat;
  logic [31:0] grad;
  out_t        res_next;

  assign kern_w = pk[53:16];
  assign kern   = (kern_w > 38'h0_8000_0000) ? 32'h8000_0000 : kern_w[31:0];
  assign gsum   = 50'({ph, 1'b0}) + 50'(pl[63:31]);
  assign gsat   = |gsum[49:32];
  assign grad   = gsat ? 32'hFFFF_FFFF : gsum[31:0];

  always_comb begin
    res_next.last_result    = sm.last;
    res_next.kernel_value   = sm.want_k ? kern : 32'd0;
    res_next.gradient_value = sm.want_g ? grad : 32'd0;
    res_next.saturated      = (sm.want_k | sm.want_g) & (sm.sat | (sm.want_g & gsat));
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vm;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

>>> hw/rtl/matern32_kernel_and_gradient.sv
// matern 3/2 kernel and lengthscale gradient, top level
// done rises once an accepted start transaction has passed the queue and the back pipeline
// throughput: one pair per cycle; set by the fully pipelined back end
//   (24 isqrt stages, 36 exp-series stages), each stage holding one pair
// busy only rises if the two-entry queue fills, which a free-running back end prevents
// rst (synchronous, active high) restores register defaults and empties the pipeline
module matern32_kernel_and_gradient import m32k_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output out_t        result
);

  // front to queue
  logic   push;
  logic   q_full;
  job_t   job_in;
  scale_t scale;

  // queue to back
  logic   q_valid;
  job_t   job_out;

  // config registers live in the front; the back reads the scale constants directly; the user must
  // change configuration only while no transaction is in flight, and the block does not enforce it
  m32k_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .job       (job_in),
    .scale     (scale)
  );

  // decouples command accept from the back pipeline
  m32k_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (q_full),
    .valid (q_valid),
    .rdata (job_out)
  );

  // arithmetic pipeline, one transaction per cycle, never stalls
  m32k_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .job      (job_out),
    .scale    (scale),
    .done     (done),
    .result   (result)
  );

endmodule

>>> tb/sv/testbench.sv
// testbench for the matern 3/2 kernel and gradient block: predicts every pair and checks results
module testbench;
  import m32k_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // expected latency plus margin, used for the drain and before config writes
  localparam int LATENCY = 69;
  localparam int DRAIN   = LATENCY + 20;
  localparam int N_RAND  = 700;

  // scoreboard: predicts kernel and gradient per accepted pair and compares results
  class kernel_scoreboard;
    logic [1:0]  dims_reg;
    logic [31:0] s3l_reg;
    logic [31:0] t3l_reg;
    logic        want_k_reg;
    logic        want_g_reg;
    out_t        pending[$];
    int          errors;
    int          checked;

    function void restore_defaults();
      dims_reg   = 2'd3;
      s3l_reg    = 32'd113512;
      t3l_reg    = 32'd196608;
      want_k_reg = 1'b1;
      want_g_reg = 1'b1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_DIMENSIONS:              dims_reg   = data[1:0];
        REG_SQRT3_OVER_LENGTH:       s3l_reg    = data;
        REG_THREE_OVER_LENGTH_CUBED: t3l_reg    = data;
        REG_WANT_KERNEL:             want_k_reg = data[0];
        REG_WANT_GRADIENT:           want_g_reg = data[0];
        default: ;
      endcase
    endfunction

    // integer square root, bit by bit
    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v    = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // exp(-u), u in q16.16, result in q1.31
    function logic [63:0] decay_q31(logic [63:0] u);
      logic [63:0]  x, k, r, p;
      logic [127:0] prod;
      if (u >= (64'd32 << FRAC_BITS)) return 0;
      x = u << (32 - FRAC_BITS);
      k = x / 64'd2977044472;
      r = x - k * 64'd2977044472;
      p = 64'h1_0000_0000;
      for (int n = 12; n >= 1; n--) begin
        prod = r * p;
        p = 64'h1_0000_0000 - ((prod >> 32) / n);
      end
      return p >> (k + 1);
    endfunction

    function void note_pair(in_t pt);
      logic [127:0] sum, sq;
      logic [63:0]  diff[3];
      logic [63:0]  d2, d, u, t;
      logic [127:0] wide;
      logic signed [63:0] sd[3];
      int   ndim;
      out_t exp_r;
      exp_r = '0;
      exp_r.last_result = pt.last_pair;
      ndim = (dims_reg == 0) ? 1 : dims_reg;
      if (want_k_reg || want_g_reg) begin
        sd[0] = 64'(pt.a_x) - 64'(pt.b_x);
        sd[1] = 64'(pt.a_y) - 64'(pt.b_y);
        sd[2] = 64'(pt.a_z) - 64'(pt.b_z);
        sum = 0;
        for (int i = 0; i < ndim; i++) begin
          diff[i] = sd[i] < 0 ? -sd[i] : sd[i];
          sq  = diff[i] * diff[i];
          sum = sum + sq;
        end
        // a 64-bit overflow of the sum also lands here since it exceeds the 32-bit d2 range
        if ((sum >> FRAC_BITS) > 128'hFFFF_FFFF) begin
          d2 = 64'hFFFF_FFFF;
          exp_r.saturated = 1'b1;
        end else begin
          d2 = 64'(sum >> FRAC_BITS);
        end
        d = int_sqrt(d2 << FRAC_BITS);
        u = (64'(s3l_reg) * d) >> FRAC_BITS;
        t = decay_q31(u);
        if (want_k_reg && t != 0) begin
          wide = (128'(64'd1 << FRAC_BITS) + u) * t;
          wide = wide >> FRAC_BITS;
          exp_r.kernel_value = (wide > 128'h8000_0000) ? 32'h8000_0000 : wide[31:0];
        end
        if (want_g_reg) begin
          wide = ((128'(t3l_reg) * d2) >> FRAC_BITS) * t;
          wide = wide >> 31;
          if (wide > 128'hFFFF_FFFF) begin
            exp_r.gradient_value = 32'hFFFF_FFFF;
            exp_r.saturated = 1'b1;
          end else begin
            exp_r.gradient_value = wide[31:0];
          end
        end
      end
      pending.push_back(exp_r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.kernel_value !== want.kernel_value) begin
        $display("%0t: kernel_value expected %h actual %h", $realtime,
                 want.kernel_value, got.kernel_value);
        errors++;
      end
      if (got.gradient_value !== want.gradient_value) begin
        $display("%0t: gradient_value expected %h actual %h", $realtime,
                 want.gradient_value, got.gradient_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $realtime,
                 want.saturated, got.saturated);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result expected %b actual %b", $realtime,
                 want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  out_t        result;

  kernel_scoreboard board;
  int pairs_sent;
  int cfg_writes;

  matern32_kernel_and_gradient uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor: every strobe is one result transaction
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // input monitor: a start transaction updates the prediction
  always @(posedge clk) begin
    if (!rst && start && !busy) board.note_pair(item);
  end

  // config monitor keeps the predictor's registers in step with the block
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
  end

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // coordinates: mostly near each other so the kernel is nontrivial, sometimes full range
  function automatic logic [31:0] rand_coord(logic [31:0] base);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return base + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      2: return base + 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return base ^ (32'd1 << $urandom_range(0, 31));
    endcase
  endfunction

  function automatic in_t rand_pair();
    in_t pt;
    pt.a_x = $urandom();
    pt.a_y = $urandom();
    pt.a_z = $urandom();
    pt.b_x = rand_coord(pt.a_x);
    pt.b_y = rand_coord(pt.a_y);
    pt.b_z = rand_coord(pt.a_z);
    pt.last_pair = 1'($urandom_range(0, 1));
    return pt;
  endfunction

  // one start transaction, waits out busy
  task automatic send_pair(in_t pt, bit no_gaps);
    if (!no_gaps) idle_cycles($urandom_range(0, 12));
    start <= 1'b1;
    item  <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    pairs_sent++;
  endtask

  // back to back transactions keep start high across items
  task automatic send_burst(int n);
    for (int i = 0; i < n; i++) begin
      start <= 1'b1;
      item  <= rand_pair();
      @(posedge clk);
      while (busy) @(posedge clk);
      pairs_sent++;
    end
    start <= 1'b0;
  endtask

  // wait until every prediction is matched, then let the pipe settle
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    idle_cycles(DRAIN);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic in_t make_pair(logic [31:0] ax, logic [31:0] bx,
                                    logic [31:0] ay, logic [31:0] by,
                                    logic [31:0] az, logic [31:0] bz, logic lst);
    in_t pt;
    pt.a_x = ax; pt.b_x = bx;
    pt.a_y = ay; pt.b_y = by;
    pt.a_z = az; pt.b_z = bz;
    pt.last_pair = lst;
    return pt;
  endfunction

  // random scales, biased toward useful lengthscales with the extremes mixed in
  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(32'h0000_1000, 32'h0008_0000);
    endcase
  endfunction

  initial begin
    board = new();
    board.restore_defaults();
    board.errors  = 0;
    board.checked = 0;
    pairs_sent = 0;
    cfg_writes = 0;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DIMENSIONS;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, zero distance, extremes, d2 overflow, small and large gaps
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
    send_pair(make_pair(32'h0001_0000, 0, 0, 0, 0, 0, 1'b1), 1'b0);
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 1'b1), 1'b0);
    send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 0, 1'b0), 1'b0);
    send_pair(make_pair(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 0,
                        0, 32'h0003_0000, 1'b0), 1'b0);
    send_pair(make_pair(32'h0100_0000, 0, 32'h0100_0000, 0, 32'h0100_0000, 0, 1'b1), 1'b0);
    send_pair(make_pair(32'h0020_0000, 0, 0, 0, 0, 0, 1'b0), 1'b0);
    drain();

    // gradient saturation: huge 3/l^3 with a moderate distance
    write_cfg(REG_THREE_OVER_LENGTH_CUBED, 32'hFFFF_FFFF);
    write_cfg(REG_SQRT3_OVER_LENGTH, 32'd0);
    send_pair(make_pair(32'h0010_0000, 0, 0, 0, 0, 0, 1'b0), 1'b0);
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1'b1), 1'b0);
    drain();

    // dimensions zero and one: y and z must be ignored
    write_cfg(REG_DIMENSIONS, 32'd0);
    write_cfg(REG_SQRT3_OVER_LENGTH, 32'hFFFF_FFFF);
    send_pair(make_pair(32'h0000_0100, 0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 9, 1'b0), 1'b0);
    drain();
    write_cfg(REG_DIMENSIONS, 32'd1);
    write_cfg(REG_SQRT3_OVER_LENGTH, 32'd113512);
    write_cfg(REG_THREE_OVER_LENGTH_CUBED, 32'd196608);
    send_pair(make_pair(32'h0001_8000, 0, 32'h1234_5678, 0, 32'h0F00_0000, 0, 1'b1), 1'b0);
    drain();

    // kernel only, gradient only, both disabled
    write_cfg(REG_DIMENSIONS, 32'd2);
    write_cfg(REG_WANT_GRADIENT, 32'd0);
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        0, 0, 1'b0), 1'b0);
    send_pair(make_pair(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 1'b1), 1'b0);
    drain();
    write_cfg(REG_WANT_KERNEL, 32'd0);
    write_cfg(REG_WANT_GRADIENT, 32'd1);
    send_pair(make_pair(32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 1'b0), 1'b0);
    drain();
    write_cfg(REG_WANT_GRADIENT, 32'd0);
    send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        1, 2, 1'b1), 1'b0);
    drain();
    // an unused register index must change nothing
    write_cfg(3'd7, 32'hFFFF_FFFF);
    write_cfg(REG_WANT_KERNEL, 32'd1);
    write_cfg(REG_WANT_GRADIENT, 32'd1);
    write_cfg(REG_DIMENSIONS, 32'd3);
    send_pair(make_pair(32'h0000_4000, 0, 32'h0000_4000, 0, 32'h0000_4000, 0, 1'b0), 1'b0);
    drain();

    // random phases, each with its own settings; a few run with no gaps at all
    for (int phase = 0; phase < 14; phase++) begin
      write_cfg(REG_DIMENSIONS, 32'($urandom_range(0, 3)));
      write_cfg(REG_SQRT3_OVER_LENGTH, rand_scale());
      write_cfg(REG_THREE_OVER_LENGTH_CUBED, rand_scale());
      write_cfg(REG_WANT_KERNEL, 32'($urandom_range(0, 5) != 0));
      write_cfg(REG_WANT_GRADIENT, 32'($urandom_range(0, 5) != 0));
      if (phase % 4 == 3) begin
        send_burst(N_RAND / 14);
      end else begin
        for (int i = 0; i < N_RAND / 14; i++) begin
          send_pair(rand_pair(), 1'b0);
          // hold off now and then until every expected result is back
          if ($urandom_range(0, 40) == 0)
            while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d pairs and %0d register writes over all dimension counts,",
             pairs_sent, cfg_writes);
    $display("enable combinations, scale extremes and saturating distances; %0d results checked",
             board.checked);
    if (board.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog: ~715 pairs with their random gaps plus drains stay far below this
  initial begin
    #5ms;
    $display("timeout");
    $display("testbench: errors");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/m32k_pkg.sv
hw/rtl/m32k_front.sv
hw/rtl/m32k_queue.sv
hw/rtl/m32k_back.sv
hw/rtl/matern32_kernel_and_gradient.sv
tb/sv/testbench.sv
